// ===== hw/rtl/pmm_pkg.sv =====
// Shared constants, codes and types of the periodic pattern matcher.
package pmm_pkg;

  // Sizes of the stores
  localparam int MAX_PATTERN = 64;
  localparam int MAX_PERIOD  = 32;

  // Field and register widths
  localparam int BYTE_W     = 8;
  localparam int FUNC_W     = 2;
  localparam int LEN_W      = 7;
  localparam int PER_W      = 6;
  localparam int POS_W      = 32;
  localparam int RUN_W      = 6;
  localparam int IDX_W      = $clog2(MAX_PATTERN);
  localparam int RES_W      = $clog2(MAX_PERIOD);
  localparam int SWEEP_W    = IDX_W + 1;
  localparam int DIV_CNT_W  = $clog2(LEN_W);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  // Saturation value of a run counter
  localparam logic [RUN_W-1:0] RUN_MAX = {RUN_W{1'b1}};

  // Reset values of the registers
  localparam logic [LEN_W-1:0] PATTERN_LENGTH_RST = LEN_W'(2);
  localparam logic [PER_W-1:0] PERIOD_LENGTH_RST  = PER_W'(1);

  // Item function codes
  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD    = 2'd0,
    FUNC_TEXT    = 2'd1,
    FUNC_RESTART = 2'd2
  } func_e;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LENGTH = 2'd0,
    REG_PERIOD_LENGTH  = 2'd1
  } cfg_reg_e;

  // Setup sequencer states
  typedef enum logic [1:0] {
    SU_LOAD,
    SU_DIVIDE,
    SU_SWEEP,
    SU_IDLE
  } setup_state_e;

  // Derived configuration seen by the datapath
  typedef struct packed {
    logic             ok;
    logic [LEN_W-1:0] m;
    logic [PER_W-1:0] p;
    logic [LEN_W-1:0] k;
    logic [LEN_W-1:0] len;
  } cfg_t;

  // One step of the compare-table rebuild
  typedef struct packed {
    logic             rd;
    logic [IDX_W-1:0] lane;
    logic [IDX_W-1:0] addr;
    logic             mask;
  } sweep_t;

  // Item held in the input register
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [BYTE_W-1:0] data;
    logic [IDX_W-1:0]  idx;
  } item_t;

endpackage

// ===== hw/rtl/pmm_setup.sv =====
// Configuration registers, quotient divider and compare-table rebuild sequencer.
module pmm_setup (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [pmm_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [pmm_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output pmm_pkg::cfg_t                    cfg_o,
  output pmm_pkg::sweep_t                  sweep_o,
  output logic                             busy_o
);
  import pmm_pkg::*;

  setup_state_e         state_q, state_d;
  logic [LEN_W-1:0]     m_q;
  logic [PER_W-1:0]     p_q;
  logic [LEN_W-1:0]     rem_q, rem_d;
  logic [LEN_W-1:0]     quo_q, quo_d;
  logic [DIV_CNT_W-1:0] div_cnt_q, div_cnt_d;
  logic [SWEEP_W-1:0]   sweep_cnt_q, sweep_cnt_d;

  logic             cfg_wr, cfg_known;
  logic             div_load, div_step, sweep_run, sweep_issue;
  logic [LEN_W-1:0] trial;
  logic             trial_ge;
  logic [LEN_W:0]   two_p_w;
  logic [LEN_W-1:0] two_p, p_ext, kp, lane_ext, j_off;

  // Register write decode
  assign cfg_wr    = cfg_valid_i && cfg_ready_o;
  assign cfg_known = (cfg_index_i == REG_PATTERN_LENGTH) ||
                     (cfg_index_i == REG_PERIOD_LENGTH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_q <= PATTERN_LENGTH_RST;
      p_q <= PERIOD_LENGTH_RST;
    end else if (cfg_wr) begin
      if (cfg_index_i == REG_PATTERN_LENGTH) begin
        m_q <= cfg_data_i[LEN_W-1:0];
      end else if (cfg_index_i == REG_PERIOD_LENGTH) begin
        p_q <= cfg_data_i[PER_W-1:0];
      end
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SU_LOAD:   state_d = SU_DIVIDE;
      SU_DIVIDE: if (div_cnt_q == DIV_CNT_W'(LEN_W - 1)) state_d = SU_SWEEP;
      SU_SWEEP:  if (sweep_cnt_q == SWEEP_W'(MAX_PATTERN)) state_d = SU_IDLE;
      SU_IDLE:   if (cfg_wr && cfg_known) state_d = SU_LOAD;
      default:   state_d = SU_LOAD;
    endcase
  end

  // State outputs
  always_comb begin
    div_load  = 1'b0;
    div_step  = 1'b0;
    sweep_run = 1'b0;
    busy_o    = 1'b1;
    unique case (state_q)
      SU_LOAD:   div_load  = 1'b1;
      SU_DIVIDE: div_step  = 1'b1;
      SU_SWEEP:  sweep_run = 1'b1;
      SU_IDLE:   busy_o    = 1'b0;
      default:   busy_o    = 1'b1;
    endcase
  end

  assign cfg_ready_o = !busy_o;
  assign sweep_issue = sweep_run && (sweep_cnt_q < SWEEP_W'(MAX_PATTERN));

  // Restoring divide of length by period, one quotient bit a cycle
  assign trial    = {rem_q[LEN_W-2:0], quo_q[LEN_W-1]};
  assign trial_ge = trial >= LEN_W'(p_q);

  always_comb begin
    rem_d       = rem_q;
    quo_d       = quo_q;
    div_cnt_d   = div_cnt_q;
    sweep_cnt_d = sweep_cnt_q;
    if (div_load) begin
      rem_d       = '0;
      quo_d       = m_q;
      div_cnt_d   = '0;
      sweep_cnt_d = '0;
    end else if (div_step) begin
      rem_d     = trial_ge ? (trial - LEN_W'(p_q)) : trial;
      quo_d     = {quo_q[LEN_W-2:0], trial_ge};
      div_cnt_d = div_cnt_q + DIV_CNT_W'(1);
    end else if (sweep_run && (sweep_cnt_q != SWEEP_W'(MAX_PATTERN))) begin
      sweep_cnt_d = sweep_cnt_q + SWEEP_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SU_LOAD;
      rem_q       <= '0;
      quo_q       <= '0;
      div_cnt_q   <= '0;
      sweep_cnt_q <= '0;
    end else begin
      state_q     <= state_d;
      rem_q       <= rem_d;
      quo_q       <= quo_d;
      div_cnt_q   <= div_cnt_d;
      sweep_cnt_q <= sweep_cnt_d;
    end
  end

  // Derived configuration
  assign two_p_w = (LEN_W + 1)'(p_q) << 1;
  assign two_p   = two_p_w[LEN_W-1:0];
  assign p_ext   = LEN_W'(p_q);
  assign kp      = m_q - rem_q;

  assign cfg_o.ok  = (p_q != '0) && (two_p_w <= (LEN_W + 1)'(m_q)) &&
                     (m_q <= LEN_W'(MAX_PATTERN)) && (p_q <= PER_W'(MAX_PERIOD));
  assign cfg_o.m   = m_q;
  assign cfg_o.p   = p_q;
  assign cfg_o.k   = quo_q;
  assign cfg_o.len = two_p + rem_q;

  // Map window lane to pattern byte: lane w expects offset len-1-w of u u v
  assign lane_ext = LEN_W'(sweep_cnt_q);
  assign j_off    = cfg_o.len - LEN_W'(1) - lane_ext;

  always_comb begin
    sweep_o.rd   = sweep_issue;
    sweep_o.lane = sweep_cnt_q[IDX_W-1:0];
    sweep_o.mask = lane_ext < cfg_o.len;
    priority if (j_off < p_ext) begin
      sweep_o.addr = j_off[IDX_W-1:0];
    end else if (j_off < two_p) begin
      sweep_o.addr = IDX_W'(j_off - p_ext);
    end else begin
      sweep_o.addr = IDX_W'(kp + j_off - two_p);
    end
  end

endmodule

// ===== hw/rtl/pmm_pattern.sv =====
// Pattern byte store and the per-lane expected-byte table of the window compare.
module pmm_pattern (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  pmm_pkg::sweep_t                sweep_i,
  input  logic                           wr_en_i,
  input  logic [pmm_pkg::IDX_W-1:0]      wr_idx_i,
  input  logic [pmm_pkg::BYTE_W-1:0]     wr_byte_i,
  output logic [pmm_pkg::BYTE_W-1:0]     exp_o [pmm_pkg::MAX_PATTERN],
  output logic [pmm_pkg::MAX_PATTERN-1:0] mask_o
);
  import pmm_pkg::*;

  logic [BYTE_W-1:0]      mem [MAX_PATTERN];
  logic [BYTE_W-1:0]      rd_q;
  logic [IDX_W-1:0]       fill_lane_q;
  logic                   fill_v_q;
  logic [IDX_W-1:0]       map_q [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] mask_q;
  logic [BYTE_W-1:0]      exp_q [MAX_PATTERN];

  // Pattern store: loads write, the rebuild reads one entry a cycle
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_idx_i] <= wr_byte_i;
    end
    if (sweep_i.rd) begin
      rd_q <= mem[sweep_i.addr];
    end
  end

  // Track the lane whose read is in flight
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_v_q <= 1'b0;
    end else begin
      fill_v_q <= sweep_i.rd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sweep_i.rd) begin
      fill_lane_q          <= sweep_i.lane;
      map_q[sweep_i.lane]  <= sweep_i.addr;
      mask_q[sweep_i.lane] <= sweep_i.mask;
    end
  end

  // Fill lanes during rebuild, follow pattern loads afterwards
  always_ff @(posedge clk_i) begin
    for (int w = 0; w < MAX_PATTERN; w++) begin
      if (fill_v_q && (fill_lane_q == IDX_W'(w))) begin
        exp_q[w] <= rd_q;
      end else if (wr_en_i && mask_q[w] && (map_q[w] == wr_idx_i)) begin
        exp_q[w] <= wr_byte_i;
      end
    end
  end

  assign exp_o  = exp_q;
  assign mask_o = mask_q;

endmodule

// ===== hw/rtl/pmm_match.sv =====
// Text window, per-residue run counters and match decision for one text item.
module pmm_match (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            step_i,
  input  logic [pmm_pkg::FUNC_W-1:0]      func_i,
  input  logic [pmm_pkg::BYTE_W-1:0]      byte_i,
  input  pmm_pkg::cfg_t                   cfg_i,
  input  logic [pmm_pkg::BYTE_W-1:0]      exp_i [pmm_pkg::MAX_PATTERN],
  input  logic [pmm_pkg::MAX_PATTERN-1:0] mask_i,
  output logic                            res_valid_o,
  output logic                            match_o,
  output logic [pmm_pkg::POS_W-1:0]       start_o
);
  import pmm_pkg::*;

  logic [BYTE_W-1:0]      win_q [MAX_PATTERN];
  logic [BYTE_W-1:0]      win_n [MAX_PATTERN];
  logic [RUN_W-1:0]       run_q [MAX_PERIOD];
  logic [POS_W-1:0]       pos_q, pos_n;
  logic [RES_W-1:0]       res_q, res_n, r;
  logic [MAX_PATTERN-1:0] lane_ok;
  logic                   hit, chk, is_text, is_restart;
  logic [RUN_W-1:0]       run_cur, run_n;
  logic [PER_W-1:0]       r_inc;

  assign is_text    = func_i == FUNC_TEXT;
  assign is_restart = func_i == FUNC_RESTART;

  // Shift the new byte in at lane zero
  always_comb begin
    win_n[0] = byte_i;
    for (int w = 1; w < MAX_PATTERN; w++) begin
      win_n[w] = win_q[w-1];
    end
  end

  // Compare every lane in use against u u v
  always_comb begin
    for (int w = 0; w < MAX_PATTERN; w++) begin
      lane_ok[w] = !mask_i[w] || (win_n[w] == exp_i[w]);
    end
  end
  assign hit = &lane_ok;

  // Run counter update for the current residue
  assign pos_n   = pos_q + POS_W'(1);
  assign chk     = cfg_i.ok && (pos_n >= POS_W'(cfg_i.len));
  assign r       = (PER_W'(res_q) >= cfg_i.p) ? '0 : res_q;
  assign run_cur = run_q[r];
  assign run_n   = !hit ? '0 : ((run_cur == RUN_MAX) ? run_cur : run_cur + RUN_W'(1));
  assign r_inc   = PER_W'(r) + PER_W'(1);
  assign res_n   = (r_inc >= cfg_i.p) ? '0 : r_inc[RES_W-1:0];

  // Result of this item
  assign res_valid_o = is_text && chk && (pos_n >= POS_W'(cfg_i.m));
  assign match_o     = LEN_W'(run_n) >= (cfg_i.k - LEN_W'(1));
  assign start_o     = pos_n - POS_W'(cfg_i.m);

  // Advance or clear text state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      res_q <= '0;
      for (int w = 0; w < MAX_PATTERN; w++) win_q[w] <= '0;
      for (int i = 0; i < MAX_PERIOD; i++) run_q[i] <= '0;
    end else if (step_i && is_restart) begin
      pos_q <= '0;
      res_q <= '0;
      for (int w = 0; w < MAX_PATTERN; w++) win_q[w] <= '0;
      for (int i = 0; i < MAX_PERIOD; i++) run_q[i] <= '0;
    end else if (step_i && is_text) begin
      pos_q <= pos_n;
      win_q <= win_n;
      if (chk) begin
        run_q[r] <= run_n;
        res_q    <= res_n;
      end
    end
  end

endmodule

// ===== hw/rtl/periodic_pattern_matcher.sv =====
// Top level of the periodic pattern matcher: input register, datapath and output register.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+------------------------------------
//  in      | sink      | in_valid_i / in_stall_o    | func_i, data_byte_i, pattern_index_i
//  out     | source    | out_valid_o / out_stall_i  | match_found_o, start_position_o
//  cfg     | sink      | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// Items are taken one per cycle while the input is not stalled; an accepted item is held in
// the input register, and any result it gives is loaded into the output register when it
// leaves that register. After reset and after each write to a known register the input
// stalls for setup: a load, the divider steps for length/period, then the rebuild of the
// per-lane expected-byte table from the pattern store through its single read port.
// A stalled output holds the input register, which then stalls the input side.
module periodic_pattern_matcher (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [pmm_pkg::FUNC_W-1:0]       func_i,
  input  logic [pmm_pkg::BYTE_W-1:0]       data_byte_i,
  input  logic [pmm_pkg::IDX_W-1:0]        pattern_index_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             match_found_o,
  output logic [pmm_pkg::POS_W-1:0]        start_position_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [pmm_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [pmm_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import pmm_pkg::*;

  cfg_t                   cfg;
  sweep_t                 sweep;
  logic                   busy;
  logic [BYTE_W-1:0]      exp_b [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] mask;

  item_t             s1_q;
  logic              s1_v_q;
  logic              accept, adv, out_load;
  logic              res_valid, res_match;
  logic [POS_W-1:0]  res_start;
  logic              out_v_q, match_q;
  logic [POS_W-1:0]  start_q;

  // Handshake
  assign out_load   = !out_v_q || !out_stall_i;
  assign adv        = s1_v_q && out_load;
  assign in_stall_o = busy || (s1_v_q && !adv);
  assign accept     = in_valid_i && !in_stall_o;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (accept) begin
      s1_v_q <= 1'b1;
    end else if (adv) begin
      s1_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q.func <= func_i;
      s1_q.data <= data_byte_i;
      s1_q.idx  <= pattern_index_i;
    end
  end

  pmm_setup u_setup (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg),
    .sweep_o     (sweep),
    .busy_o      (busy)
  );

  pmm_pattern u_pattern (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .sweep_i   (sweep),
    .wr_en_i   (adv && (s1_q.func == FUNC_LOAD)),
    .wr_idx_i  (s1_q.idx),
    .wr_byte_i (s1_q.data),
    .exp_o     (exp_b),
    .mask_o    (mask)
  );

  pmm_match u_match (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (adv),
    .func_i      (s1_q.func),
    .byte_i      (s1_q.data),
    .cfg_i       (cfg),
    .exp_i       (exp_b),
    .mask_i      (mask),
    .res_valid_o (res_valid),
    .match_o     (res_match),
    .start_o     (res_start)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_load) begin
      out_v_q <= adv && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && res_valid) begin
      match_q <= res_match;
      start_q <= res_start;
    end
  end

  assign out_valid_o      = out_v_q;
  assign match_found_o    = match_q;
  assign start_position_o = start_q;

`ifndef NO_ASSERTIONS
  a_out_from_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_v_q) |-> $past(adv))
    else $error("result appeared without an item leaving the input register");

  a_s1_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q && !adv) |=> s1_v_q)
    else $error("held item dropped from the input register");

  a_no_result_non_text : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && (s1_q.func != FUNC_TEXT)) |=> !out_v_q)
    else $error("non-text item produced a result");

  a_busy_empty_pipe : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) && !$past(cfg_valid_i) |-> !s1_v_q)
    else $error("setup started without a register write while an item was held");
`endif

endmodule

// ===== tb/sv/tb_periodic_pattern_matcher.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the periodic pattern matcher, with its own matcher model.
module tb_periodic_pattern_matcher;
  import pmm_pkg::*;

  // Codes the package leaves unnamed
  localparam logic [FUNC_W-1:0]    FUNC_UNUSED  = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_3 = 2'd3;

  localparam int TOTAL_ITEMS   = 1120;
  localparam int DRAIN_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_REPORTS   = 60;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] start;
  } occurrence_t;

  // Clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #2 clk_i = ~clk_i;

  // Block ports
  logic                  in_valid   = 1'b0;
  logic [FUNC_W-1:0]     in_func    = '0;
  logic [BYTE_W-1:0]     in_data    = '0;
  logic [IDX_W-1:0]      in_index   = '0;
  logic                  out_stall  = 1'b0;
  logic                  cfg_valid  = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;
  logic                  in_stall;
  logic                  out_valid;
  logic                  match_found;
  logic [POS_W-1:0]      start_position;
  logic                  cfg_ready;

  periodic_pattern_matcher dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .func_i           (in_func),
    .data_byte_i      (in_data),
    .pattern_index_i  (in_index),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .match_found_o    (match_found),
    .start_position_o (start_position),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data)
  );

  // Matcher model state
  logic [LEN_W-1:0]  cur_len;
  logic [PER_W-1:0]  cur_per;
  logic [BYTE_W-1:0] pat_mem [MAX_PATTERN];
  logic [BYTE_W-1:0] window  [MAX_PATTERN];
  logic [RUN_W-1:0]  run_cnt [MAX_PERIOD];
  logic [POS_W-1:0]  text_pos;
  logic [RES_W-1:0]  residue;

  occurrence_t pending_hits [$];
  occurrence_t head_hit;

  int unsigned errors     = 0;
  int unsigned items_sent = 0;
  logic        in_quiet   = 1'b0;
  logic        out_quiet  = 1'b0;

  // Byte alphabet of the current phase
  logic              narrow = 1'b0;
  logic [BYTE_W-1:0] sym_a  = '0;
  logic [BYTE_W-1:0] sym_b  = '0;

  task automatic report_mismatch(input string msg);
    // Keep the log short when the block is badly off
    if (errors < MAX_REPORTS) $display("MISMATCH @%0t: %s", $time, msg);
    errors++;
  endtask

  task automatic clear_text();
    int i;
    for (i = 0; i < MAX_PATTERN; i++) window[i] = '0;
    for (i = 0; i < MAX_PERIOD; i++) run_cnt[i] = '0;
    text_pos = '0;
    residue  = '0;
  endtask

  function automatic logic cfg_usable(input int unsigned m, input int unsigned p);
    return (p >= 1) && (2 * p <= m) && (m <= MAX_PATTERN) && (p <= MAX_PERIOD);
  endfunction

  // Expected byte at offset j of u u v
  function automatic logic [BYTE_W-1:0] uuv_byte(input int unsigned j, input int unsigned p,
                                                 input int unsigned kp);
    int unsigned a;
    if (j < p) a = j;
    else if (j < 2 * p) a = j - p;
    else a = kp + j - 2 * p;
    return pat_mem[a];
  endfunction

  // Advance the matcher model by one item and queue the occurrence it reports
  task automatic advance_matcher(input logic [FUNC_W-1:0] f, input logic [BYTE_W-1:0] b,
                                 input logic [IDX_W-1:0] pi);
    int          i;
    int unsigned m, p, k, kp, len, r;
    logic        hit;
    occurrence_t occ;
    m = cur_len;
    p = cur_per;
    case (f)
      FUNC_LOAD: pat_mem[pi] = b;
      FUNC_RESTART: clear_text();
      FUNC_TEXT: begin
        for (i = MAX_PATTERN - 1; i > 0; i--) window[i] = window[i-1];
        window[0] = b;
        text_pos  = text_pos + 1'b1;
        if (cfg_usable(m, p)) begin
          k   = m / p;
          kp  = k * p;
          len = 2 * p + m - kp;
          if (text_pos >= len) begin
            hit = 1'b1;
            for (i = 0; i < len; i++) begin
              if (window[len-1-i] != uuv_byte(i, p, kp)) hit = 1'b0;
            end
            // A shrunk period folds a stale residue back to zero
            if (residue >= p) residue = '0;
            r = residue;
            if (hit) begin
              if (run_cnt[r] != RUN_MAX) run_cnt[r] = run_cnt[r] + 1'b1;
            end else begin
              run_cnt[r] = '0;
            end
            residue = (r + 1 >= p) ? '0 : RES_W'(r + 1);
            if (text_pos >= m) begin
              occ.found = (run_cnt[r] >= k - 1);
              occ.start = text_pos - POS_W'(m);
              pending_hits.push_back(occ);
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  // Send one item, then idle for a random gap
  task automatic send_item(input logic [FUNC_W-1:0] f, input logic [BYTE_W-1:0] b,
                           input logic [IDX_W-1:0] pi);
    int unsigned gap;
    in_valid <= 1'b1;
    in_func  <= f;
    in_data  <= b;
    in_index <= pi;
    do @(posedge clk_i); while (in_stall);
    advance_matcher(f, b, pi);
    if (f != FUNC_UNUSED) items_sent++;
    if ($urandom_range(0, 29) == 0) in_quiet = ~in_quiet;
    gap = in_quiet ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_text(input logic [BYTE_W-1:0] b);
    send_item(FUNC_TEXT, b, IDX_W'($urandom_range(0, MAX_PATTERN - 1)));
  endtask

  function automatic logic [BYTE_W-1:0] pick_byte();
    if (narrow) return $urandom_range(0, 1) ? sym_a : sym_b;
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  // Drain all expected results, then let in-flight items settle
  task automatic wait_idle();
    int unsigned spin;
    spin = 0;
    in_valid <= 1'b0;
    while (pending_hits.size() != 0 && spin < DRAIN_LIMIT) begin
      @(posedge clk_i);
      spin++;
    end
    if (pending_hits.size() != 0) begin
      report_mismatch($sformatf("%0d expected results never arrived", pending_hits.size()));
      pending_hits.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
    case (idx)
      REG_PATTERN_LENGTH: cur_len = val;
      REG_PERIOD_LENGTH:  cur_per = val[PER_W-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Reset values: length 2, period 1, so only store entry 0 is compared
  task automatic test_defaults();
    send_item(FUNC_LOAD, 8'h00, 6'd0);
    send_item(FUNC_LOAD, 8'h00, 6'd1);
    send_text(8'h00);
    send_text(8'h00);
    send_text(8'hFF);
    send_item(FUNC_LOAD, 8'hFF, 6'd0);
    send_text(8'hFF);
    send_item(FUNC_UNUSED, 8'hFF, 6'h3F);
    send_item(FUNC_LOAD, 8'hFF, 6'h3F);
    send_item(FUNC_RESTART, 8'h00, 6'h00);
    send_text(8'hFF);
    send_text(8'hFF);
    send_text(8'h00);
    wait_idle();
  endtask

  task automatic try_bad_config(input logic [CFG_DATA_W-1:0] m, input logic [CFG_DATA_W-1:0] p);
    wait_idle();
    write_reg(REG_PATTERN_LENGTH, m);
    write_reg(REG_PERIOD_LENGTH, p);
    send_text(BYTE_W'($urandom_range(0, 255)));
  endtask

  // Unusable settings only shift the window; unknown register indexes are dropped
  task automatic test_invalid_configs();
    try_bad_config(7'd0, 7'd1);
    try_bad_config(7'h7F, 7'd1);
    try_bad_config(7'd64, 7'd0);
    try_bad_config(7'd64, 7'h7F);
    try_bad_config(7'd65, 7'd32);
    try_bad_config(7'd5, 7'd3);
    wait_idle();
    write_reg(REG_UNUSED_2, 7'h7F);
    write_reg(REG_UNUSED_3, 7'h00);
    send_text(BYTE_W'($urandom_range(0, 255)));
    wait_idle();
  endtask

  // Phases of random settings, each with a periodic pattern and text built from it
  task automatic test_random_phases();
    int unsigned phase, m, p, k, kp, target, act, reps, n, i;
    logic        ok;
    phase = 0;
    while (items_sent < TOTAL_ITEMS) begin
      case (phase)
        0: begin m = 64; p = 32; end
        1: begin m = 64; p = 1; end
        2: begin m = 63; p = 31; end
        3: begin m = 2; p = 1; end
        default: begin
          act = $urandom_range(0, 9);
          if (act == 0) begin
            m = $urandom_range(0, 127);
            p = $urandom_range(0, 63);
          end else if (act <= 2) begin
            m = $urandom_range(13, 64);
            p = $urandom_range(1, m / 2);
          end else begin
            m = $urandom_range(2, 12);
            p = $urandom_range(1, m / 2);
          end
        end
      endcase
      ok     = cfg_usable(m, p);
      narrow = ($urandom_range(0, 2) == 0);
      sym_a  = BYTE_W'($urandom_range(0, 255));
      sym_b  = BYTE_W'($urandom_range(0, 255));

      // Reprogram while idle; counters carry over unless the text restarts
      wait_idle();
      if ($urandom_range(0, 1)) begin
        write_reg(REG_PATTERN_LENGTH, CFG_DATA_W'(m));
        write_reg(REG_PERIOD_LENGTH, {1'($urandom_range(0, 1)), PER_W'(p)});
      end else begin
        write_reg(REG_PERIOD_LENGTH, {1'($urandom_range(0, 1)), PER_W'(p)});
        write_reg(REG_PATTERN_LENGTH, CFG_DATA_W'(m));
      end
      if ($urandom_range(0, 1)) send_item(FUNC_RESTART, pick_byte(), IDX_W'($urandom));

      // Load a pattern with period p, now and then with one byte broken
      if (ok) begin
        k  = m / p;
        kp = k * p;
        for (i = 0; i < p; i++) send_item(FUNC_LOAD, pick_byte(), IDX_W'(i));
        for (i = p; i < m; i++) send_item(FUNC_LOAD, pat_mem[i % p], IDX_W'(i));
        if ($urandom_range(0, 3) == 0)
          send_item(FUNC_LOAD, pick_byte(), IDX_W'($urandom_range(0, m - 1)));
      end

      target = items_sent + ((m > 12) ? 200 : 60);
      while (items_sent < target) begin
        act = $urandom_range(0, 99);
        if (!ok) begin
          if (act < 80) send_text(pick_byte());
          else if (act < 90) send_item(FUNC_LOAD, pick_byte(), IDX_W'($urandom));
          else if (act < 95) send_item(FUNC_RESTART, pick_byte(), IDX_W'($urandom));
          else send_item(FUNC_UNUSED, pick_byte(), IDX_W'($urandom));
        end else if (act < 70) begin
          // Repeats of the period, sometimes closed by the tail
          reps = $urandom_range(1, k + 2);
          repeat (reps) begin
            for (i = 0; i < p; i++) send_text(pat_mem[i]);
          end
          if ($urandom_range(0, 1)) begin
            for (i = kp; i < m; i++) send_text(pat_mem[i]);
          end
        end else if (act < 85) begin
          n = $urandom_range(1, 4);
          repeat (n) send_text(pick_byte());
        end else if (act < 88) begin
          send_item(FUNC_RESTART, pick_byte(), IDX_W'($urandom));
        end else if (act < 93) begin
          send_item(FUNC_LOAD, pick_byte(), IDX_W'($urandom_range(0, MAX_PATTERN - 1)));
        end else begin
          send_item(FUNC_UNUSED, pick_byte(), IDX_W'($urandom));
        end
      end
      phase++;
    end
  endtask

  // Stall the result side at random ahead of each result it takes
  initial begin : result_stall
    int unsigned n;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 29) == 0) out_quiet = ~out_quiet;
      n = out_quiet ? 0 : $urandom_range(0, 11);
      out_stall <= (n != 0);
      if (n != 0) begin
        repeat (n) @(posedge clk_i);
        out_stall <= 1'b0;
      end
      do @(posedge clk_i); while (!(out_valid && !out_stall));
    end
  end

  // Compare each accepted result with the oldest expected occurrence
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      if (pending_hits.size() == 0) begin
        report_mismatch($sformatf("unexpected result found=%0b start=%0d",
                                  match_found, start_position));
      end else begin
        head_hit = pending_hits.pop_front();
        if (match_found !== head_hit.found)
          report_mismatch($sformatf("start %0d: match_found %0b, expected %0b",
                                    head_hit.start, match_found, head_hit.found));
        if (start_position !== head_hit.start)
          report_mismatch($sformatf("start_position %0d, expected %0d",
                                    start_position, head_hit.start));
      end
    end
  end

  // Bound the run
  initial begin : watchdog
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : main_seq
    cur_len = PATTERN_LENGTH_RST;
    cur_per = PERIOD_LENGTH_RST;
    clear_text();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_defaults();
    test_invalid_configs();
    test_random_phases();
    wait_idle();
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
